### hw/rtl/msgenc_pkg.sv
// Shared types, operation codes, status codes and format bytes of the stream encoder.
package msgenc_pkg;

   localparam int unsigned CmdDepth = 2;
   localparam int unsigned MaxBytes = 5;

   localparam logic [7:0] BufferSizeReset = 8'd255;

   // Operation codes.
   localparam logic [3:0] OpUint    = 4'd0;
   localparam logic [3:0] OpStr     = 4'd1;
   localparam logic [3:0] OpBin     = 4'd2;
   localparam logic [3:0] OpBool    = 4'd3;
   localparam logic [3:0] OpNil     = 4'd4;
   localparam logic [3:0] OpMap     = 4'd5;
   localparam logic [3:0] OpArray   = 4'd6;
   localparam logic [3:0] OpPayload = 4'd7;
   localparam logic [3:0] OpRestart = 4'd8;

   // Status codes.
   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StNoRoom  = 2'd1;
   localparam logic [1:0] StTooLong = 2'd2;
   localparam logic [1:0] StSeqErr  = 2'd3;

   // Format bytes.
   localparam logic [7:0] FixIntMax = 8'h7f;
   localparam logic [7:0] Uint8Tag  = 8'hcc;
   localparam logic [7:0] Uint16Tag = 8'hcd;
   localparam logic [7:0] Uint32Tag = 8'hce;
   localparam logic [7:0] FixStrTag = 8'ha0;
   localparam logic [7:0] Str8Tag   = 8'hd9;
   localparam logic [7:0] Bin8Tag   = 8'hc4;
   localparam logic [7:0] TrueTag   = 8'hc3;
   localparam logic [7:0] FalseTag  = 8'hc2;
   localparam logic [7:0] NilTag    = 8'hc0;
   localparam logic [7:0] FixMapTag = 8'h80;
   localparam logic [7:0] Map16Tag  = 8'hde;
   localparam logic [7:0] FixArrTag = 8'h90;
   localparam logic [7:0] Arr16Tag  = 8'hdc;

   // One classified operation: the bytes to emit (first in element 0), how many,
   // the status, and the message size after the operation. No bytes means a single
   // status-only result.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [2:0]               nbytes;
      logic [1:0]               status;
      logic [7:0]               size;
   } cmd_type;

endpackage

### hw/rtl/msgenc_front.sv
// Front end: accepts operations, checks room and sequence, keeps the message state.
module msgenc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [3:0]            opcode,
   input  logic [31:0]           number,
   input  logic [15:0]           length,
   input  logic [7:0]            count,
   input  logic                  flag,
   input  logic [7:0]            data_byte,
   input  logic                  csr_write,
   input  logic [7:0]            csr_data,
   output msgenc_pkg::cmd_type   cmd
);

   logic [7:0] buffer_size_ff, buffer_size_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] payload_left_ff, payload_left_in;

   logic [8:0] room;
   logic [8:0] need;
   logic       grows;
   logic       sets_payload;
   logic       clears;
   logic       consumes;
   logic [1:0] status;
   logic [2:0] nbytes;
   logic [msgenc_pkg::MaxBytes-1:0][7:0] bytes;

   assign room = (position_ff >= buffer_size_ff) ? 9'd0
                 : ({1'b0, buffer_size_ff} - {1'b0, position_ff});

   always_comb begin
      status       = msgenc_pkg::StOk;
      nbytes       = 3'd0;
      bytes        = '0;
      need         = 9'd0;
      grows        = 1'b0;
      sets_payload = 1'b0;
      clears       = 1'b0;
      consumes     = 1'b0;
      if (opcode == msgenc_pkg::OpRestart) begin
         clears = 1'b1;
      end else if (opcode == msgenc_pkg::OpPayload) begin
         if (payload_left_ff == 8'd0) begin
            status = msgenc_pkg::StSeqErr;
         end else begin
            consumes = 1'b1;
            nbytes   = 3'd1;
            bytes[0] = data_byte;
         end
      end else if (payload_left_ff != 8'd0) begin
         status = msgenc_pkg::StSeqErr;
      end else begin
         unique case (opcode) inside
            msgenc_pkg::OpUint: begin
               grows = 1'b1;
               if (number <= {24'd0, msgenc_pkg::FixIntMax}) begin
                  need = 9'd1; nbytes = 3'd1;
                  bytes[0] = number[7:0];
               end else if (number[31:8] == 24'd0) begin
                  need = 9'd2; nbytes = 3'd2;
                  bytes[0] = msgenc_pkg::Uint8Tag;
                  bytes[1] = number[7:0];
               end else if (number[31:16] == 16'd0) begin
                  need = 9'd3; nbytes = 3'd3;
                  bytes[0] = msgenc_pkg::Uint16Tag;
                  bytes[1] = number[15:8];
                  bytes[2] = number[7:0];
               end else begin
                  need = 9'd5; nbytes = 3'd5;
                  bytes[0] = msgenc_pkg::Uint32Tag;
                  bytes[1] = number[31:24];
                  bytes[2] = number[23:16];
                  bytes[3] = number[15:8];
                  bytes[4] = number[7:0];
               end
            end
            msgenc_pkg::OpStr, msgenc_pkg::OpBin: begin
               if (length[15:8] != 8'd0) begin
                  status = msgenc_pkg::StTooLong;
               end else begin
                  grows        = 1'b1;
                  sets_payload = 1'b1;
                  if (opcode == msgenc_pkg::OpStr && length[7:5] == 3'd0) begin
                     need = {1'b0, length[7:0]} + 9'd1; nbytes = 3'd1;
                     bytes[0] = msgenc_pkg::FixStrTag | length[7:0];
                  end else begin
                     need = {1'b0, length[7:0]} + 9'd2; nbytes = 3'd2;
                     bytes[0] = (opcode == msgenc_pkg::OpStr) ? msgenc_pkg::Str8Tag
                                : msgenc_pkg::Bin8Tag;
                     bytes[1] = length[7:0];
                  end
               end
            end
            msgenc_pkg::OpBool: begin
               grows = 1'b1; need = 9'd1; nbytes = 3'd1;
               bytes[0] = flag ? msgenc_pkg::TrueTag : msgenc_pkg::FalseTag;
            end
            msgenc_pkg::OpNil: begin
               grows = 1'b1; need = 9'd1; nbytes = 3'd1;
               bytes[0] = msgenc_pkg::NilTag;
            end
            msgenc_pkg::OpMap, msgenc_pkg::OpArray: begin
               grows = 1'b1;
               if (count[7:4] == 4'd0) begin
                  need = 9'd1; nbytes = 3'd1;
                  bytes[0] = ((opcode == msgenc_pkg::OpMap) ? msgenc_pkg::FixMapTag
                              : msgenc_pkg::FixArrTag) | count;
               end else begin
                  need = 9'd3; nbytes = 3'd3;
                  bytes[0] = (opcode == msgenc_pkg::OpMap) ? msgenc_pkg::Map16Tag
                             : msgenc_pkg::Arr16Tag;
                  bytes[1] = 8'd0;
                  bytes[2] = count;
               end
            end
            default: begin
               status = msgenc_pkg::StSeqErr;
            end
         endcase
         // A refused operation leaves the message untouched.
         if (grows && need > room) begin
            status       = msgenc_pkg::StNoRoom;
            nbytes       = 3'd0;
            grows        = 1'b0;
            sets_payload = 1'b0;
         end
      end
   end

   always_comb begin
      buffer_size_in  = csr_write ? csr_data : buffer_size_ff;
      position_in     = position_ff;
      payload_left_in = payload_left_ff;
      if (accept) begin
         if (clears) begin
            position_in     = 8'd0;
            payload_left_in = 8'd0;
         end else begin
            if (grows) begin
               position_in = position_ff + need[7:0];
            end
            if (sets_payload) begin
               payload_left_in = length[7:0];
            end
            if (consumes) begin
               payload_left_in = payload_left_ff - 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff  <= msgenc_pkg::BufferSizeReset;
         position_ff     <= 8'd0;
         payload_left_ff <= 8'd0;
      end else begin
         buffer_size_ff  <= buffer_size_in;
         position_ff     <= position_in;
         payload_left_ff <= payload_left_in;
      end
   end

   always_comb begin
      cmd.bytes  = bytes;
      cmd.nbytes = nbytes;
      cmd.status = status;
      cmd.size   = position_in;
   end

endmodule

### hw/rtl/msgenc_cmdq.sv
// Short command queue between the front end and the byte emitter.
module msgenc_cmdq #(
   parameter int unsigned Depth = msgenc_pkg::CmdDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  msgenc_pkg::cmd_type  push_cmd,
   output logic                 full,
   input  logic                 pop,
   output msgenc_pkg::cmd_type  pop_cmd,
   output logic                 empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   msgenc_pkg::cmd_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == FullCnt);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/msgenc_back.sv
// Back end: walks through one command at a time; one result per cycle while popped.
module msgenc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  msgenc_pkg::cmd_type  q_cmd,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic [7:0]           out_byte,
   output logic                 byte_valid,
   output logic                 last,
   output logic [1:0]           status,
   output logic [7:0]           message_size,
   output logic                 empty,
   input  logic                 pop
);

   msgenc_pkg::cmd_type cmd_ff, cmd_in;
   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic       done;

   assign byte_valid   = (cmd_ff.nbytes != 3'd0);
   assign last         = !byte_valid || (idx_ff == cmd_ff.nbytes - 3'd1);
   assign out_byte     = byte_valid ? cmd_ff.bytes[idx_ff] : 8'd0;
   assign status       = cmd_ff.status;
   assign message_size = cmd_ff.size;
   assign empty        = !valid_ff;

   // The held command is finished once its final result is taken.
   assign done  = !valid_ff || (pop && last);
   assign q_pop = done && !q_empty;

   always_comb begin
      cmd_in   = cmd_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (done) begin
         valid_in = !q_empty;
         idx_in   = 3'd0;
         if (!q_empty) begin
            cmd_in = q_cmd;
         end
      end else if (pop) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      cmd_ff <= cmd_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff && byte_valid |-> idx_ff < cmd_ff.nbytes)
      else $error("byte index beyond the command length");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      valid_ff && pop && !last |=> valid_ff && idx_ff == $past(idx_ff) + 3'd1)
      else $error("emitter did not advance to the next byte");

   a_bytes_ok: assert property (@(posedge clock) disable iff (reset)
      valid_ff && byte_valid |-> status == msgenc_pkg::StOk)
      else $error("byte emitted with a failure status");

endmodule

### hw/rtl/msgpack_stream_encoder_unit.sv
// Top level of the bounded-size MessagePack stream encoder.
// Each operation transaction on the req_ side is checked and classified in the
// cycle it is taken and queued as one command; the emitter then gives one result
// per cycle on the rsp_ side while the receiver pops: one to five byte results (five
// for a 32-bit unsigned integer, one for payload bytes and small items), or a single
// status-only result for restart and refused operations. The front end takes a new
// operation every cycle while the command queue has room. The buffer size register
// may be written at any time through csr_ and is always ready, but should only
// change while the encoder is idle. No clearing pass follows reset.
module msgpack_stream_encoder_unit #(
   parameter int unsigned CmdDepth = msgenc_pkg::CmdDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_number,
   input  logic [15:0] req_length,
   input  logic [7:0]  req_count,
   input  logic        req_flag,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_message_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   msgenc_pkg::cmd_type front_cmd;
   msgenc_pkg::cmd_type q_cmd;
   logic                q_full, q_empty, q_pop;
   logic                accept;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   msgenc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .opcode    (req_opcode),
      .number    (req_number),
      .length    (req_length),
      .count     (req_count),
      .flag      (req_flag),
      .data_byte (req_data_byte),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (front_cmd)
   );

   msgenc_cmdq #(
      .Depth (CmdDepth)
   ) u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_cmd),
      .empty    (q_empty)
   );

   msgenc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_cmd        (q_cmd),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .out_byte     (rsp_out_byte),
      .byte_valid   (rsp_byte_valid),
      .last         (rsp_last),
      .status       (rsp_status),
      .message_size (rsp_message_size),
      .empty        (rsp_empty),
      .pop          (rsp_pop)
   );

endmodule

### sim/msgenc_checker.sv
// Checker for the stream encoder: watches all three channels, predicts results and compares.
`timescale 1ns / 100ps

module msgenc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_number,
   input  logic [15:0] req_length,
   input  logic [7:0]  req_count,
   input  logic        req_flag,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_byte_valid,
   input  logic        rsp_last,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_message_size,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   output int          error_count,
   output int          outstanding
);

   localparam int MaxReported = 10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic [1:0] status;
      logic [7:0] size;
   } enc_result_type;

   enc_result_type expected_results[$];
   enc_result_type observed;
   enc_result_type predicted;

   logic [7:0] buffer_size;
   logic [7:0] position;
   logic [7:0] payload_left;

   // Works out the results of one accepted operation and advances the message state.
   task automatic encode_operation(input logic [3:0] op, input logic [31:0] number,
                                   input logic [15:0] length, input logic [7:0] count,
                                   input logic flag, input logic [7:0] data_byte);
      logic [7:0]     code_bytes [5];
      logic [1:0]     st;
      int             nbytes;
      int             reserve;
      int             room;
      enc_result_type res;
      st = msgenc_pkg::StOk;
      nbytes = 0;
      reserve = 0;
      room = (position >= buffer_size) ? 0 : int'(buffer_size) - int'(position);
      if (op == msgenc_pkg::OpRestart) begin
         position = 8'd0;
         payload_left = 8'd0;
      end else if (op == msgenc_pkg::OpPayload) begin
         if (payload_left == 8'd0) begin
            st = msgenc_pkg::StSeqErr;
         end else begin
            code_bytes[0] = data_byte;
            nbytes = 1;
         end
      end else if (op > msgenc_pkg::OpRestart || payload_left != 8'd0) begin
         st = msgenc_pkg::StSeqErr;
      end else begin
         case (op) inside
            msgenc_pkg::OpUint: begin
               if (number[31:7] == '0) begin
                  code_bytes[0] = number[7:0];
                  nbytes = 1;
               end else if (number[31:8] == '0) begin
                  code_bytes[0] = msgenc_pkg::Uint8Tag;
                  code_bytes[1] = number[7:0];
                  nbytes = 2;
               end else if (number[31:16] == '0) begin
                  code_bytes[0] = msgenc_pkg::Uint16Tag;
                  code_bytes[1] = number[15:8];
                  code_bytes[2] = number[7:0];
                  nbytes = 3;
               end else begin
                  code_bytes[0] = msgenc_pkg::Uint32Tag;
                  code_bytes[1] = number[31:24];
                  code_bytes[2] = number[23:16];
                  code_bytes[3] = number[15:8];
                  code_bytes[4] = number[7:0];
                  nbytes = 5;
               end
            end
            msgenc_pkg::OpStr, msgenc_pkg::OpBin: begin
               if (length[15:8] != '0) begin
                  st = msgenc_pkg::StTooLong;
               end else if (op == msgenc_pkg::OpStr && length[15:5] == '0) begin
                  code_bytes[0] = msgenc_pkg::FixStrTag | length[7:0];
                  nbytes = 1;
               end else begin
                  code_bytes[0] = (op == msgenc_pkg::OpStr) ? msgenc_pkg::Str8Tag
                                  : msgenc_pkg::Bin8Tag;
                  code_bytes[1] = length[7:0];
                  nbytes = 2;
               end
            end
            msgenc_pkg::OpBool: begin
               code_bytes[0] = flag ? msgenc_pkg::TrueTag : msgenc_pkg::FalseTag;
               nbytes = 1;
            end
            msgenc_pkg::OpNil: begin
               code_bytes[0] = msgenc_pkg::NilTag;
               nbytes = 1;
            end
            default: begin
               if (count[7:4] == '0) begin
                  code_bytes[0] = ((op == msgenc_pkg::OpMap) ? msgenc_pkg::FixMapTag
                                   : msgenc_pkg::FixArrTag) | count;
                  nbytes = 1;
               end else begin
                  code_bytes[0] = (op == msgenc_pkg::OpMap) ? msgenc_pkg::Map16Tag
                                  : msgenc_pkg::Arr16Tag;
                  code_bytes[1] = 8'h00;
                  code_bytes[2] = count;
                  nbytes = 3;
               end
            end
         endcase
         // A string or binary header reserves room for its whole payload as well.
         reserve = nbytes + ((op == msgenc_pkg::OpStr || op == msgenc_pkg::OpBin)
                             ? int'(length) : 0);
         if (st == msgenc_pkg::StOk && room < reserve) begin
            st = msgenc_pkg::StNoRoom;
            nbytes = 0;
         end
      end
      if (nbytes != 0) begin
         position = position + 8'(reserve);
         if (op == msgenc_pkg::OpPayload)
            payload_left = payload_left - 8'd1;
         else if (op == msgenc_pkg::OpStr || op == msgenc_pkg::OpBin)
            payload_left = length[7:0];
      end
      if (nbytes == 0) begin
         res = {8'h00, 1'b0, 1'b1, st, position};
         expected_results.push_back(res);
      end else begin
         for (int i = 0; i < nbytes; i++) begin
            res = {code_bytes[i], 1'b1, i == nbytes - 1, msgenc_pkg::StOk, position};
            expected_results.push_back(res);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         buffer_size = msgenc_pkg::BufferSizeReset;
         position = 8'd0;
         payload_left = 8'd0;
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready)
            buffer_size = csr_data;
         if (req_push && !req_full)
            encode_operation(req_opcode, req_number, req_length, req_count, req_flag,
                             req_data_byte);
         if (rsp_pop && !rsp_empty) begin
            observed = {rsp_out_byte, rsp_byte_valid, rsp_last, rsp_status, rsp_message_size};
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= MaxReported)
                  $display({"%0t: result transaction with none expected: byte %02h",
                            " valid %0b last %0b status %0d size %0d"},
                           $realtime, observed.out_byte, observed.byte_valid,
                           observed.last, observed.status, observed.size);
            end else begin
               predicted = expected_results.pop_front();
               if (observed !== predicted) begin
                  error_count++;
                  if (error_count <= MaxReported)
                     $display({"%0t: mismatch: expected byte %02h valid %0b last %0b status %0d",
                               " size %0d, got byte %02h valid %0b last %0b status %0d size %0d"},
                              $realtime, predicted.out_byte, predicted.byte_valid,
                              predicted.last, predicted.status, predicted.size,
                              observed.out_byte, observed.byte_valid, observed.last,
                              observed.status, observed.size);
               end
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

### sim/testbench.sv
// Top of the encoder testbench: clock, reset, stimulus, result stalls and the verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int         CycleLimit = 400000;
   localparam int         HoldCycles = 80;
   localparam int         MaxPayload = 64;
   localparam logic [3:0] OpUnused   = 4'd15;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [3:0]  req_opcode = '0;
   logic [31:0] req_number = '0;
   logic [15:0] req_length = '0;
   logic [7:0]  req_count = '0;
   logic        req_flag = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_message_size;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   int error_count;
   int outstanding;
   int items_sent = 0;
   int burst_left = 0;
   bit steady_sender = 1'b0;
   int hold_requests = 0;
   int holds_served = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   msgpack_stream_encoder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_number       (req_number),
      .req_length       (req_length),
      .req_count        (req_count),
      .req_flag         (req_flag),
      .req_data_byte    (req_data_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .rsp_message_size (rsp_message_size),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   msgenc_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_number       (req_number),
      .req_length       (req_length),
      .req_count        (req_count),
      .req_flag         (req_flag),
      .req_data_byte    (req_data_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .rsp_message_size (rsp_message_size),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one operation; the value lands in the field that the opcode uses and
   // every other field carries random bits.
   task automatic push_op(input logic [3:0] op, input logic [31:0] value);
      logic [31:0] number;
      logic [15:0] length;
      logic [7:0]  count;
      logic [7:0]  data_byte;
      logic        flag;
      int          gap;
      number = $urandom;
      length = 16'($urandom);
      count = 8'($urandom);
      data_byte = 8'($urandom);
      flag = 1'($urandom);
      case (op) inside
         msgenc_pkg::OpUint:                       number = value;
         msgenc_pkg::OpStr, msgenc_pkg::OpBin:     length = value[15:0];
         msgenc_pkg::OpMap, msgenc_pkg::OpArray:   count = value[7:0];
         msgenc_pkg::OpBool:                       flag = value[0];
         msgenc_pkg::OpPayload:                    data_byte = value[7:0];
         default: ;
      endcase
      req_push <= 1'b1;
      req_opcode <= op;
      req_number <= number;
      req_length <= length;
      req_count <= count;
      req_flag <= flag;
      req_data_byte <= data_byte;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else if (!steady_sender) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // Stops offering and waits for every predicted result; the count is read at
   // the falling edge so that the checker has seen the last transaction.
   task automatic idle_until_drained();
      req_push <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_buffer_size(input logic [7:0] size);
      idle_until_drained();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_sequence();
      int          pick;
      int          nbytes;
      logic [15:0] length;
      logic [3:0]  op;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         op = 4'($urandom_range(0, 15));
         push_op(op, $urandom);
      end else if (pick < 16) begin
         push_op(msgenc_pkg::OpRestart, $urandom);
      end else if (pick < 32) begin
         case ($urandom_range(0, 4))
            0:       push_op(msgenc_pkg::OpUint, $urandom_range(0, 127));
            1:       push_op(msgenc_pkg::OpUint, $urandom_range(128, 255));
            2:       push_op(msgenc_pkg::OpUint, $urandom_range(256, 65535));
            3:       push_op(msgenc_pkg::OpUint, $urandom_range(65536, 32'hffff_ffff));
            default: push_op(msgenc_pkg::OpUint, $urandom);
         endcase
      end else if (pick < 55) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            length = 16'($urandom_range(0, 6));
         else if (pick < 85)
            length = 16'($urandom_range(7, 40));
         else if (pick < 92)
            length = 16'($urandom_range(41, 255));
         else
            length = 16'($urandom_range(256, 65535));
         push_op($urandom_range(0, 1) ? msgenc_pkg::OpStr : msgenc_pkg::OpBin,
                 {16'd0, length});
         nbytes = (length > 16'd255) ? 0 : int'(length);
         // Now and then the payload is cut short, leaving the encoder waiting.
         if (nbytes != 0 && $urandom_range(0, 99) < 15)
            nbytes = $urandom_range(0, nbytes - 1);
         // Long payloads are sent only in part, which keeps the item count bounded.
         if (nbytes > MaxPayload)
            nbytes = $urandom_range(0, MaxPayload);
         repeat (nbytes) push_op(msgenc_pkg::OpPayload, $urandom);
      end else if (pick < 65) begin
         push_op(msgenc_pkg::OpBool, $urandom);
      end else if (pick < 72) begin
         push_op(msgenc_pkg::OpNil, $urandom);
      end else begin
         op = $urandom_range(0, 1) ? msgenc_pkg::OpMap : msgenc_pkg::OpArray;
         case ($urandom_range(0, 2))
            0:       push_op(op, $urandom_range(0, 15));
            1:       push_op(op, $urandom_range(16, 255));
            default: push_op(op, $urandom);
         endcase
      end
   endtask

   task automatic run_random(input int n);
      int target;
      target = items_sent + n;
      while (items_sent < target) random_sequence();
   endtask

   // Result side: stall patterns of varying density, plus long hold-offs on request.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rsp_pop <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(8, 60);
         end
         rx_mode_left--;
         case (rx_mode)
            0:       rsp_pop <= !reset;
            1:       rsp_pop <= !reset && $urandom_range(0, 1);
            default: rsp_pop <= !reset && ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Encoding forms and their boundaries at the reset buffer size.
      push_op(msgenc_pkg::OpUint, 32'h0000_0000);
      push_op(msgenc_pkg::OpUint, 32'h0000_007f);
      push_op(msgenc_pkg::OpUint, 32'h0000_0080);
      push_op(msgenc_pkg::OpUint, 32'h0000_ffff);
      push_op(msgenc_pkg::OpUint, 32'h0001_0000);
      push_op(msgenc_pkg::OpUint, 32'hffff_ffff);
      push_op(msgenc_pkg::OpStr, 0);
      push_op(msgenc_pkg::OpStr, 2);
      push_op(msgenc_pkg::OpPayload, 8'h00);
      push_op(msgenc_pkg::OpPayload, 8'hff);
      // A restart abandons the pending payload of a long string.
      push_op(msgenc_pkg::OpStr, 40);
      push_op(msgenc_pkg::OpRestart, 0);
      push_op(msgenc_pkg::OpBin, 1);
      push_op(msgenc_pkg::OpPayload, 8'h5a);
      push_op(msgenc_pkg::OpStr, 256);
      push_op(msgenc_pkg::OpBin, 16'hffff);
      push_op(msgenc_pkg::OpBool, 1);
      push_op(msgenc_pkg::OpBool, 0);
      push_op(msgenc_pkg::OpNil, 0);
      push_op(msgenc_pkg::OpMap, 8'hff);
      push_op(msgenc_pkg::OpArray, 8'h0f);
      push_op(msgenc_pkg::OpPayload, 8'h33);
      push_op(OpUnused, 0);
      // Another operation while a payload byte is still owed is a sequence error.
      push_op(msgenc_pkg::OpStr, 1);
      push_op(msgenc_pkg::OpNil, 0);
      push_op(msgenc_pkg::OpPayload, 8'h01);

      write_buffer_size(8'd0);
      run_random(10);
      write_buffer_size(8'd6);
      push_op(msgenc_pkg::OpRestart, 0);
      run_random(20);

      // The receiver holds off while the sender keeps offering, so the input stalls.
      write_buffer_size(8'd255);
      push_op(msgenc_pkg::OpRestart, 0);
      steady_sender = 1'b1;
      hold_requests <= hold_requests + 1;
      run_random(15);
      steady_sender = 1'b0;
      run_random(30);

      // Lowering the size below the current position leaves no room at all.
      push_op(msgenc_pkg::OpRestart, 0);
      repeat (20) push_op(msgenc_pkg::OpNil, 0);
      write_buffer_size(8'd3);
      run_random(8);

      write_buffer_size(8'($urandom_range(8, 64)));
      push_op(msgenc_pkg::OpRestart, 0);
      run_random(25);

      idle_until_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
